// ===== rtl/dlle_pkg.sv =====
// shared types and constants for the doubly linked list engine
// no dependencies

package dlle_pkg;

    localparam int NODE_COUNT = 64;
    localparam int ADDR_W     = 6;
    localparam int VALUE_W    = 32;
    localparam int FREE_W     = $clog2(NODE_COUNT) + 1;

    typedef enum logic [1:0] {
        FN_INSERT   = 2'd0,
        FN_ERASE    = 2'd1,
        FN_TRAVERSE = 2'd2,
        FN_NONE     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BADADDR = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_REQ  = 2'd0,
        RD_HEAD = 2'd1,
        RD_LINK = 2'd2
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_INS1  = 2'd1,
        WR_INS2  = 2'd2,
        WR_ERASE = 2'd3
    } t_wr_sel;

    typedef enum logic [1:0] {
        OUT_ZERO = 2'd0,
        OUT_SLOT = 2'd1,
        OUT_CUR  = 2'd2
    } t_out_src;

    typedef struct packed {
        logic     capture;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     cur_load;
        t_wr_sel  wr_sel;
        logic     out_load;
        t_status  out_status;
        t_out_src out_src;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  bad_ins;
        logic  bad_era;
        logic  full;
        logic  link_null;
        logic  out_free;
    } t_dp_stat;

endpackage

// ===== rtl/doubly_linked_list_engine.sv =====
// doubly linked list engine, top level
// instantiates dlle_ctrl and dlle_dp, depends on dlle_pkg
//
// a request (func, node_addr, value) is taken when i_in_valid is high and o_in_stall
// is low. one request is worked at a time; o_in_stall is high from acceptance until
// the edge that loads its last result into the output register; the next request can
// be taken right after that edge while that result still waits on the output channel.
// insert: one result with the new slot, after a read of the request's node, a write
// of the new node and a link update. erase: one result, after a read and a relink.
// errors (bad address, full) give one result from the decode step. func 3 gives
// no result. insert and erase wait on the registered read of the link tables.
// traverse: the first element follows the read of the head, then one element
// per cycle while the output is not stalled, set by the single read port of the
// tables; the final element has o_last set. an empty list gives one empty-status result.
// when i_out_stall is high while a result is held, the output register holds and the
// engine waits, with no result lost. after reset the list is empty and slot 1 is next;
// link valid bits clear at once, so no clearing pass is needed.

module doubly_linked_list_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_func,
    input  logic [dlle_pkg::ADDR_W-1:0]         i_node_addr,
    input  logic signed [dlle_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic [dlle_pkg::ADDR_W-1:0]         o_result_addr,
    output logic signed [dlle_pkg::VALUE_W-1:0] o_result_value,
    output logic                                o_last
);
    import dlle_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dlle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dlle_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_func         (i_func),
        .i_node_addr    (i_node_addr),
        .i_value        (i_value),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_result_addr  (o_result_addr),
        .o_result_value (o_result_value),
        .o_last         (o_last)
    );

endmodule

// ===== rtl/dlle_dp.sv =====
// datapath: link and value tables, allocation pointer, request and result registers
// depends on dlle_pkg

module dlle_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dlle_pkg::t_dp_cmd             i_cmd,
    output dlle_pkg::t_dp_stat            o_stat,
    input  logic [1:0]                    i_func,
    input  logic [dlle_pkg::ADDR_W-1:0]   i_node_addr,
    input  logic signed [dlle_pkg::VALUE_W-1:0] i_value,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [1:0]                    o_status,
    output logic [dlle_pkg::ADDR_W-1:0]   o_result_addr,
    output logic signed [dlle_pkg::VALUE_W-1:0] o_result_value,
    output logic                          o_last
);
    import dlle_pkg::*;

    logic [ADDR_W-1:0]  r_nxt_mem [NODE_COUNT];
    logic [ADDR_W-1:0]  r_prv_mem [NODE_COUNT];
    logic [VALUE_W-1:0] r_val_mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_nxt_vld;

    logic [ADDR_W-1:0]  r_nxt_q;
    logic               r_nxt_q_vld;
    logic [ADDR_W-1:0]  r_prv_q;
    logic [VALUE_W-1:0] r_val_q;

    logic [FREE_W-1:0]  r_next_free;
    t_func              r_func;
    logic [ADDR_W-1:0]  r_addr;
    logic [VALUE_W-1:0] r_value;
    logic [ADDR_W-1:0]  r_cur;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_last;

    logic [ADDR_W-1:0]  link;
    logic [ADDR_W-1:0]  slot;
    logic [ADDR_W-1:0]  rd_addr;
    logic               alloc;
    logic               out_free;

    logic               nxt_we;
    logic [ADDR_W-1:0]  nxt_wa;
    logic [ADDR_W-1:0]  nxt_wd;
    logic               prv_we;
    logic [ADDR_W-1:0]  prv_wa;
    logic [ADDR_W-1:0]  prv_wd;
    logic               val_we;

    assign link     = r_nxt_q_vld ? r_nxt_q : '0;
    assign slot     = r_next_free[ADDR_W-1:0];
    assign alloc    = {1'b0, r_addr} < r_next_free;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_stat.func      = r_func;
    assign o_stat.bad_ins   = !alloc;
    assign o_stat.bad_era   = (r_addr == '0) || !alloc;
    assign o_stat.full      = r_next_free >= FREE_W'(NODE_COUNT);
    assign o_stat.link_null = link == '0;
    assign o_stat.out_free  = out_free;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_REQ:  rd_addr = r_addr;
            RD_HEAD: rd_addr = '0;
            RD_LINK: rd_addr = link;
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        nxt_we = 1'b0;
        nxt_wa = slot;
        nxt_wd = link;
        prv_we = 1'b0;
        prv_wa = slot;
        prv_wd = r_addr;
        val_we = 1'b0;
        case (i_cmd.wr_sel)
            WR_INS1: begin
                nxt_we = 1'b1;
                prv_we = 1'b1;
                val_we = 1'b1;
            end
            WR_INS2: begin
                nxt_we = 1'b1;
                nxt_wa = r_addr;
                nxt_wd = slot;
                prv_we = link != '0;
                prv_wa = link;
                prv_wd = slot;
            end
            WR_ERASE: begin
                nxt_we = 1'b1;
                nxt_wa = r_prv_q;
                nxt_wd = link;
                prv_we = link != '0;
                prv_wa = link;
                prv_wd = r_prv_q;
            end
            default: begin
            end
        endcase
    end

    // tables
    always_ff @(posedge i_clk) begin
        if (nxt_we) begin
            r_nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we) begin
            r_prv_mem[prv_wa] <= prv_wd;
        end
        if (val_we) begin
            r_val_mem[slot] <= r_value;
        end
        if (i_cmd.rd_en) begin
            r_nxt_q <= r_nxt_mem[rd_addr];
            r_prv_q <= r_prv_mem[rd_addr];
            r_val_q <= r_val_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nxt_vld   <= '0;
            r_nxt_q_vld <= 1'b0;
            r_next_free <= FREE_W'(1);
        end else begin
            if (nxt_we) begin
                r_nxt_vld[nxt_wa] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_nxt_q_vld <= r_nxt_vld[rd_addr];
            end
            if (i_cmd.wr_sel == WR_INS2) begin
                r_next_free <= r_next_free + FREE_W'(1);
            end
        end
    end

    // request capture and walk pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func <= FN_NONE;
        end else if (i_cmd.capture) begin
            r_func <= t_func'(i_func);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr  <= i_node_addr;
            r_value <= i_value;
        end
        if (i_cmd.cur_load) begin
            r_cur <= link;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_last   <= i_cmd.out_last;
            case (i_cmd.out_src)
                OUT_SLOT: begin
                    r_out_addr  <= slot;
                    r_out_value <= '0;
                end
                OUT_CUR: begin
                    r_out_addr  <= r_cur;
                    r_out_value <= r_val_q;
                end
                default: begin
                    r_out_addr  <= '0;
                    r_out_value <= '0;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_addr  = r_out_addr;
    assign o_result_value = r_out_value;
    assign o_last         = r_out_last;

endmodule

// ===== rtl/dlle_ctrl.sv =====
// controller: sequences table reads, writes and result loads for each request
// depends on dlle_pkg

module dlle_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dlle_pkg::t_dp_stat  i_stat,
    output dlle_pkg::t_dp_cmd   o_cmd
);
    import dlle_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DEC    = 7'b0000010,
        S_INS_W1 = 7'b0000100,
        S_INS_W2 = 7'b0001000,
        S_ERA_W  = 7'b0010000,
        S_HEAD   = 7'b0100000,
        S_WALK   = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic              is_last;

    assign is_last    = i_stat.link_null || (r_cnt == ADDR_W'(NODE_COUNT - 2));
    assign o_in_stall = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '{capture: 1'b0, rd_en: 1'b0, rd_sel: RD_REQ, cur_load: 1'b0,
                    wr_sel: WR_NONE, out_load: 1'b0, out_status: ST_OK,
                    out_src: OUT_ZERO, out_last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                case (i_stat.func)
                    FN_INSERT: begin
                        if (i_stat.bad_ins || i_stat.full) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = i_stat.bad_ins ? ST_BADADDR : ST_FULL;
                                n_state          = S_IDLE;
                            end
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_INS_W1;
                        end
                    end
                    FN_ERASE: begin
                        if (i_stat.bad_era) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_BADADDR;
                                n_state          = S_IDLE;
                            end
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_ERA_W;
                        end
                    end
                    FN_TRAVERSE: begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_HEAD;
                        n_cnt        = '0;
                        n_state      = S_HEAD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_INS_W1: begin
                o_cmd.wr_sel = WR_INS1;
                n_state      = S_INS_W2;
            end
            S_INS_W2: begin
                if (i_stat.out_free) begin
                    o_cmd.wr_sel   = WR_INS2;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = OUT_SLOT;
                    n_state        = S_IDLE;
                end
            end
            S_ERA_W: begin
                if (i_stat.out_free) begin
                    o_cmd.wr_sel   = WR_ERASE;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_HEAD: begin
                if (i_stat.link_null) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = ST_EMPTY;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_sel   = RD_LINK;
                    o_cmd.cur_load = 1'b1;
                    n_state        = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = OUT_CUR;
                    o_cmd.out_last = is_last;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_en    = 1'b1;
                        o_cmd.rd_sel   = RD_LINK;
                        o_cmd.cur_load = 1'b1;
                        n_cnt          = r_cnt + ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
